FILE: design/sarq_pkg.sv
// Shared lane indexes and counts for the shortest-arc quaternion datapath.
`default_nettype none
package sarq_pkg;
   localparam int unsigned QLANES = 4;
   localparam int unsigned AX = 0;
   localparam int unsigned AY = 1;
   localparam int unsigned AZ = 2;
   localparam int unsigned AW = 3;
endpackage
`default_nettype wire

FILE: design/sarq_sqrt.sv
// Pipelined floor integer square root, one result bit per stage, with side data.
`default_nettype none
module sarq_sqrt
   import sarq_pkg::*;
#(
   parameter int IW = 64,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [IW-1:0]   in_rad,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [IW/2-1:0] out_root,
   output logic [SW-1:0]   out_side
);
   localparam int N = IW / 2;

   logic          vld_ff  [N];
   logic [N:0]    rem_ff  [N];
   logic [N-1:0]  root_ff [N];
   logic [IW-1:0] rad_ff  [N];
   logic [SW-1:0] side_ff [N];

   genvar k;
   for (k = 0; k < N; k++) begin : g_step
      logic          vld_prev;
      logic [N:0]    rem_prev;
      logic [N-1:0]  root_prev;
      logic [IW-1:0] rad_prev;
      logic [SW-1:0] side_prev;
      logic [N+2:0]  part;
      logic [N+2:0]  trial;
      logic [N+2:0]  diff;
      logic          ge;
      logic [N:0]    rem_in;
      logic [N-1:0]  root_in;
      logic [IW-1:0] rad_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         part    = {rem_prev, rad_prev[IW-1:IW-2]};
         trial   = (N+3)'({root_prev, 2'b01});
         diff    = part - trial;
         ge      = (part >= trial);
         rem_in  = ge ? diff[N:0] : part[N:0];
         root_in = {root_prev[N-2:0], ge};
         rad_in  = {rad_prev[IW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];
endmodule
`default_nettype wire

FILE: design/sarq_div.sv
// Pipelined restoring divider: four magnitudes over one length, one quotient bit per stage.
`default_nettype none
module sarq_div
   import sarq_pkg::*;
#(
   parameter int LW = 34,
   parameter int MW = 33,
   parameter int QB = 16,
   parameter int SW = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [LW-1:0]                in_len,
   input  logic [QLANES-1:0][MW-1:0]    in_mag,
   input  logic [SW-1:0]                in_side,
   output logic                         out_valid,
   output logic [QLANES-1:0][QB-1:0]    out_quo,
   output logic [SW-1:0]                out_side
);
   logic                      vld_ff  [QB];
   logic [LW-1:0]             len_ff  [QB];
   logic [QLANES-1:0][LW-1:0] rem_ff  [QB];
   logic [QLANES-1:0][QB-1:0] quo_ff  [QB];
   logic [SW-1:0]             side_ff [QB];

   genvar k;
   for (k = 0; k < QB; k++) begin : g_step
      logic                      vld_prev;
      logic [LW-1:0]             len_prev;
      logic [QLANES-1:0][QB-1:0] quo_prev;
      logic [SW-1:0]             side_prev;
      logic [QLANES-1:0][LW:0]   num;
      logic [LW:0]               diff;
      logic                      ge;
      logic [QLANES-1:0][LW-1:0] rem_in;
      logic [QLANES-1:0][QB-1:0] quo_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign len_prev  = in_len;
         assign quo_prev  = '0;
         assign side_prev = in_side;
         always_comb begin
            for (int l = 0; l < QLANES; l++) begin
               num[l] = (LW+1)'(in_mag[l]);
            end
         end
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign len_prev  = len_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign side_prev = side_ff[k-1];
         always_comb begin
            for (int l = 0; l < QLANES; l++) begin
               num[l] = {rem_ff[k-1][l], 1'b0};
            end
         end
      end

      always_comb begin
         diff = '0;
         ge   = 1'b0;
         for (int l = 0; l < QLANES; l++) begin
            diff      = num[l] - (LW+1)'(len_prev);
            ge        = (num[l] >= (LW+1)'(len_prev));
            rem_in[l] = ge ? diff[LW-1:0] : num[l][LW-1:0];
            quo_in[l] = {quo_prev[l][QB-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         len_ff[k]  <= len_prev;
         rem_ff[k]  <= rem_in;
         quo_ff[k]  <= quo_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = vld_ff[QB-1];
   assign out_quo   = quo_ff[QB-1];
   assign out_side  = side_ff[QB-1];
endmodule
`default_nettype wire

FILE: design/shortest_arc_rotation_quaternion.sv
// Top level: fully pipelined shortest-arc rotation quaternion between two vectors.
//
// Usage:
//  - Input words: raise start with req_src_* and req_dst_* (signed Q3.12 at the
//    default width). A word is taken at every edge where start is high and busy
//    is low; busy stays low, so a new word may enter every cycle.
//  - Result words: rsp_valid pulses for one cycle with rsp_rot_x/y/z/w (Q1.14,
//    16384 is one) and rsp_degenerate. Results leave in input order.
//  - Depth: set by the two bit-per-stage square root pipelines and the
//    bit-per-stage normalizing divider.
//  - Throughput: one word per cycle.
//  - Reset clears every stage valid bit; words in flight are dropped.
//  - The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module shortest_arc_rotation_quaternion
   import sarq_pkg::*;
#(
   parameter int IN_WIDTH      = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [IN_WIDTH-1:0]        req_src_x,
   input  logic signed [IN_WIDTH-1:0]        req_src_y,
   input  logic signed [IN_WIDTH-1:0]        req_src_z,
   input  logic signed [IN_WIDTH-1:0]        req_dst_x,
   input  logic signed [IN_WIDTH-1:0]        req_dst_y,
   input  logic signed [IN_WIDTH-1:0]        req_dst_z,
   output logic                              rsp_valid,
   output logic signed [OUT_FRAC_BITS+1:0]   rsp_rot_x,
   output logic signed [OUT_FRAC_BITS+1:0]   rsp_rot_y,
   output logic signed [OUT_FRAC_BITS+1:0]   rsp_rot_z,
   output logic signed [OUT_FRAC_BITS+1:0]   rsp_rot_w,
   output logic                              rsp_degenerate
);
   localparam int W       = IN_WIDTH;
   localparam int OF      = OUT_FRAC_BITS;
   localparam int OW      = OF + 2;
   localparam int TWO_FB  = 2 * (W - 4);
   localparam int MW      = 2 * W + 1;
   localparam int DW      = 2 * W + 2;
   localparam int SQW     = 4 * W + 4;
   localparam int LW      = 2 * W + 2;
   localparam int ML      = MW / 2;
   localparam int MH      = MW - ML;
   localparam int QB      = OF + 2;
   localparam int PW      = MW + OF + 2;
   localparam int SHL     = (OF >= TWO_FB) ? OF - TWO_FB : 0;
   localparam int SHR     = (OF >= TWO_FB) ? 1 : TWO_FB - OF;
   localparam int TOL_EXP = (TWO_FB >= 20) ? TWO_FB - 20 : 0;

   localparam logic [LW-1:0] TOL   = LW'(1) << TOL_EXP;
   localparam logic [QB-1:0] ONE_Q = QB'(1) << OF;
   localparam logic [PW-1:0] ONE_P = PW'(1) << OF;

   typedef struct packed {
      logic [2:0]           sgn;
      logic [2:0][MW-1:0]   mag;
      logic [DW-1:0]        dot;
   } s1_type;

   typedef struct packed {
      logic [QLANES-1:0]           sgn;
      logic [QLANES-1:0][MW-1:0]   mag;
   } s2_type;

   typedef struct packed {
      logic                        degen;
      logic [QLANES-1:0]           sgn;
      logic [QLANES-1:0][OF:0]     pass;
   } s3_type;

   assign busy = 1'b0;

   // stage 1: input register
   logic                v1_ff;
   logic signed [W-1:0] s1_ff [3];
   logic signed [W-1:0] d1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      s1_ff[AX] <= req_src_x;
      s1_ff[AY] <= req_src_y;
      s1_ff[AZ] <= req_src_z;
      d1_ff[AX] <= req_dst_x;
      d1_ff[AY] <= req_dst_y;
      d1_ff[AZ] <= req_dst_z;
   end

   // stage 2: products
   logic                  v2_ff;
   logic signed [2*W-1:0] ca2_in [3], cb2_in [3], sqs2_in [3], sqd2_in [3], dp2_in [3];
   logic signed [2*W-1:0] ca2_ff [3], cb2_ff [3], sqs2_ff [3], sqd2_ff [3], dp2_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ca2_in[i]  = s1_ff[(i + 1) % 3] * d1_ff[(i + 2) % 3];
         cb2_in[i]  = d1_ff[(i + 1) % 3] * s1_ff[(i + 2) % 3];
         sqs2_in[i] = s1_ff[i] * s1_ff[i];
         sqd2_in[i] = d1_ff[i] * d1_ff[i];
         dp2_in[i]  = s1_ff[i] * d1_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      ca2_ff  <= ca2_in;
      cb2_ff  <= cb2_in;
      sqs2_ff <= sqs2_in;
      sqd2_ff <= sqd2_in;
      dp2_ff  <= dp2_in;
   end

   // stage 3: cross terms, squared lengths, dot product
   logic                  v3_ff;
   logic signed [2*W:0]   cd;
   logic [2:0][MW-1:0]    cm3_in, cm3_ff;
   logic [2:0]            cs3_in, cs3_ff;
   logic [2*W-1:0]        ls3_in, ls3_ff, ld3_in, ld3_ff;
   logic signed [DW-1:0]  dot3_in, dot3_ff;

   always_comb begin
      cd = '0;
      for (int i = 0; i < 3; i++) begin
         cd        = (2*W+1)'(ca2_ff[i]) - (2*W+1)'(cb2_ff[i]);
         cm3_in[i] = cd[2*W] ? MW'(-cd) : MW'(cd);
         cs3_in[i] = cd[2*W];
      end
      ls3_in  = $unsigned(sqs2_ff[0]) + $unsigned(sqs2_ff[1]) + $unsigned(sqs2_ff[2]);
      ld3_in  = $unsigned(sqd2_ff[0]) + $unsigned(sqd2_ff[1]) + $unsigned(sqd2_ff[2]);
      dot3_in = DW'(dp2_ff[0]) + DW'(dp2_ff[1]) + DW'(dp2_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      cm3_ff  <= cm3_in;
      cs3_ff  <= cs3_in;
      ls3_ff  <= ls3_in;
      ld3_ff  <= ld3_in;
      dot3_ff <= dot3_in;
   end

   // stages 4-5: |s|^2 * |d|^2 as two partial products
   logic               v4_ff, v5_ff;
   logic [3*W-1:0]     lh4_ff, ll4_ff;
   logic [4*W-1:0]     prod5_ff;
   s1_type             sd4_ff, sd5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      lh4_ff     <= ls3_ff * ld3_ff[2*W-1:W];
      ll4_ff     <= ls3_ff * ld3_ff[W-1:0];
      sd4_ff.sgn <= cs3_ff;
      sd4_ff.mag <= cm3_ff;
      sd4_ff.dot <= dot3_ff;
      prod5_ff   <= ((4*W)'(lh4_ff) << W) + (4*W)'(ll4_ff);
      sd5_ff     <= sd4_ff;
   end

   logic           vq1;
   logic [2*W-1:0] root1;
   s1_type         side1;

   sarq_sqrt #(
      .IW (4 * W),
      .SW ($bits(s1_type))
   ) u_sqrt_len (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_rad    (prod5_ff),
      .in_side   (sd5_ff),
      .out_valid (vq1),
      .out_root  (root1),
      .out_side  (side1)
   );

   // stage 6: scalar part
   logic                      v6_ff;
   logic signed [DW:0]        wsum;
   logic [QLANES-1:0][MW-1:0] mag6_in, mag6_ff;

   always_comb begin
      wsum = $signed({{(DW+1-2*W){1'b0}}, root1}) + (DW+1)'($signed(side1.dot));
      mag6_in[AX] = side1.mag[AX];
      mag6_in[AY] = side1.mag[AY];
      mag6_in[AZ] = side1.mag[AZ];
      mag6_in[AW] = wsum[MW-1:0];
   end

   logic [QLANES-1:0] sgn6_ff, sgn7_ff, sgn8_ff, sgn9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= vq1;
      end
      mag6_ff <= mag6_in;
      sgn6_ff <= {1'b0, side1.sgn};
   end

   // stages 7-9: squared length of the raw quaternion
   logic                         v7_ff, v8_ff, v9_ff;
   logic [QLANES-1:0][MW+MH-1:0] ph7_ff;
   logic [QLANES-1:0][MW+ML-1:0] pl7_ff;
   logic [QLANES-1:0][2*MW-1:0]  sq8_ff;
   logic [SQW-1:0]               sum9_in, sum9_ff;
   logic [QLANES-1:0][MW-1:0]    mag7_ff, mag8_ff, mag9_ff;

   always_comb begin
      sum9_in = '0;
      for (int l = 0; l < QLANES; l++) begin
         sum9_in = sum9_in + SQW'(sq8_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
      for (int l = 0; l < QLANES; l++) begin
         ph7_ff[l] <= mag6_ff[l] * mag6_ff[l][MW-1:ML];
         pl7_ff[l] <= mag6_ff[l] * mag6_ff[l][ML-1:0];
         sq8_ff[l] <= ((2*MW)'(ph7_ff[l]) << ML) + (2*MW)'(pl7_ff[l]);
      end
      sum9_ff <= sum9_in;
      mag7_ff <= mag6_ff;
      mag8_ff <= mag7_ff;
      mag9_ff <= mag8_ff;
      sgn7_ff <= sgn6_ff;
      sgn8_ff <= sgn7_ff;
      sgn9_ff <= sgn8_ff;
   end

   s2_type  sd9;
   assign sd9.sgn = sgn9_ff;
   assign sd9.mag = mag9_ff;

   logic          vq2;
   logic [LW-1:0] len2;
   s2_type        side2;

   sarq_sqrt #(
      .IW (SQW),
      .SW ($bits(s2_type))
   ) u_sqrt_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v9_ff),
      .in_rad    (sum9_ff),
      .in_side   (sd9),
      .out_valid (vq2),
      .out_root  (len2),
      .out_side  (side2)
   );

   // tolerance test and pass-through values for the short case
   s3_type        sd3_in;
   logic [PW-1:0] pw;

   always_comb begin
      pw           = '0;
      sd3_in.degen = (len2 < TOL);
      sd3_in.sgn   = side2.sgn;
      for (int l = 0; l < QLANES; l++) begin
         pw = PW'(side2.mag[l]);
         if (OF >= TWO_FB) begin
            pw = pw << SHL;
         end else begin
            pw = (pw + (PW'(1) << (SHR - 1))) >> SHR;
         end
         sd3_in.pass[l] = (pw > ONE_P) ? ONE_P[OF:0] : pw[OF:0];
      end
   end

   logic                      vq3;
   logic [QLANES-1:0][QB-1:0] quo3;
   s3_type                    side3;

   sarq_div #(
      .LW (LW),
      .MW (MW),
      .QB (QB),
      .SW ($bits(s3_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vq2),
      .in_len    (len2),
      .in_mag    (side2.mag),
      .in_side   (sd3_in),
      .out_valid (vq3),
      .out_quo   (quo3),
      .out_side  (side3)
   );

   // output stage: round, saturate, apply sign
   logic                      vo_ff;
   logic                      degen_ff;
   logic [QB:0]               tp;
   logic [QB-1:0]             qv;
   logic [OF:0]               m;
   logic [QLANES-1:0][OW-1:0] rot_in, rot_ff;

   always_comb begin
      tp = '0;
      qv = '0;
      m  = '0;
      for (int l = 0; l < QLANES; l++) begin
         tp = (QB+1)'(quo3[l]) + (QB+1)'(1);
         qv = tp[QB:1];
         m  = (qv > ONE_Q) ? ONE_Q[OF:0] : qv[OF:0];
         if (side3.degen) begin
            m = side3.pass[l];
         end
         rot_in[l] = side3.sgn[l] ? (OW'(0) - OW'(m)) : OW'(m);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= vq3;
      end
      rot_ff   <= rot_in;
      degen_ff <= side3.degen;
   end

   assign rsp_valid      = vo_ff;
   assign rsp_rot_x      = rot_ff[AX];
   assign rsp_rot_y      = rot_ff[AY];
   assign rsp_rot_z      = rot_ff[AZ];
   assign rsp_rot_w      = rot_ff[AW];
   assign rsp_degenerate = degen_ff;
endmodule
`default_nettype wire

FILE: design/sarq_checker.sv
// Port-level checker for the shortest-arc quaternion block, with its bind.
`default_nettype none
module sarq_checker #(
   parameter int IN_WIDTH      = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic signed [IN_WIDTH-1:0]      req_src_x,
   input logic signed [IN_WIDTH-1:0]      req_src_y,
   input logic signed [IN_WIDTH-1:0]      req_src_z,
   input logic                            rsp_valid,
   input logic signed [OUT_FRAC_BITS+1:0] rsp_rot_x,
   input logic signed [OUT_FRAC_BITS+1:0] rsp_rot_y,
   input logic signed [OUT_FRAC_BITS+1:0] rsp_rot_z,
   input logic signed [OUT_FRAC_BITS+1:0] rsp_rot_w,
   input logic                            rsp_degenerate
);
   localparam int LATENCY = 4 * IN_WIDTH + OUT_FRAC_BITS + 14;
   localparam int CW      = $clog2(LATENCY + 1);
   localparam logic signed [OUT_FRAC_BITS+1:0] ONE = (OUT_FRAC_BITS+2)'(1) << OUT_FRAC_BITS;

   logic [CW-1:0] settle_ff;
   logic [CW-1:0] settle_in;
   logic          settled;

   assign settled   = (settle_ff == CW'(LATENCY));
   assign settle_in = settled ? settle_ff : settle_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= '0;
      end else begin
         settle_ff <= settle_in;
      end
   end

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted word produced no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (settled && rsp_valid) |-> $past(start && !busy, LATENCY))
      else $error("result without matching input word");

   a_zero_src: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_src_x == 0 && req_src_y == 0 && req_src_z == 0)
      |-> ##LATENCY (rsp_valid && rsp_degenerate && rsp_rot_x == 0 && rsp_rot_y == 0
                     && rsp_rot_z == 0 && rsp_rot_w == 0))
      else $error("zero source not reported degenerate");

   a_w_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_degenerate) |-> (rsp_rot_w >= 0 && rsp_rot_w <= ONE))
      else $error("scalar part out of range");
endmodule

bind shortest_arc_rotation_quaternion sarq_checker #(
   .IN_WIDTH      (IN_WIDTH),
   .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_sarq_checker (.*);
`default_nettype wire

FILE: test/sarq_checker.sv
// Checker for the shortest-arc quaternion block: predicts each result word and compares.
module sarq_scoreboard
   import sarq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] src_x,
   input  logic signed [15:0] src_y,
   input  logic signed [15:0] src_z,
   input  logic signed [15:0] dst_x,
   input  logic signed [15:0] dst_y,
   input  logic signed [15:0] dst_z,
   input  logic               rsp_valid,
   input  logic signed [15:0] rot_x,
   input  logic signed [15:0] rot_y,
   input  logic signed [15:0] rot_z,
   input  logic signed [15:0] rot_w,
   input  logic               degenerate,
   output int                 fails,
   output int                 pending,
   output int                 checked,
   output int                 degen_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [15:0] w;
      logic               degen;
   } rotation_type;

   rotation_type rotations_due[$];

   function automatic bit [63:0] floor_root(bit [127:0] n);
      bit [63:0] r;
      bit [63:0] t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (128'(t) * 128'(t) <= n) r = t;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] clamp_q14(bit [63:0] mag, bit neg);
      bit [63:0] m;
      m = (mag > 64'd16384) ? 64'd16384 : mag;
      return neg ? -16'(m) : 16'(m);
   endfunction

   function automatic rotation_type arc_rotation(longint sx, longint sy, longint sz,
                                                 longint dx, longint dy, longint dz);
      rotation_type res;
      longint     c[QLANES];
      bit [63:0]  ls, ld, len, mag, q;
      bit [127:0] sum, num;
      bit         degen;
      logic signed [15:0] o[QLANES];
      ls = sx * sx + sy * sy + sz * sz;
      ld = dx * dx + dy * dy + dz * dz;
      c[AX] = sy * dz - dy * sz;
      c[AY] = sz * dx - dz * sx;
      c[AZ] = sx * dy - dx * sy;
      c[AW] = longint'(floor_root(128'(ls) * 128'(ld))) + (sx * dx + sy * dy + sz * dz);
      sum = '0;
      for (int i = 0; i < QLANES; i++) begin
         mag = c[i] < 0 ? -c[i] : c[i];
         sum += 128'(mag) * 128'(mag);
      end
      len = floor_root(sum);
      degen = len < 64'd16;
      for (int i = 0; i < QLANES; i++) begin
         mag = c[i] < 0 ? -c[i] : c[i];
         if (degen) begin
            q = (mag + 64'd512) >> 10;
         end else begin
            num = (128'(mag) << 15) + 128'(len);
            q = 64'(num / (128'(len) << 1));
         end
         o[i] = clamp_q14(q, c[i] < 0);
      end
      res.x = o[AX];
      res.y = o[AY];
      res.z = o[AZ];
      res.w = o[AW];
      res.degen = degen;
      return res;
   endfunction

   initial begin
      fails = 0;
      pending = 0;
      checked = 0;
      degen_seen = 0;
   end

   always @(posedge clock) begin
      rotation_type want;
      if (!reset) begin
         if (start && !busy)
            rotations_due.push_back(arc_rotation(src_x, src_y, src_z, dst_x, dst_y, dst_z));
         if (rsp_valid) begin
            if (rotations_due.size() == 0) begin
               fails++;
               if (fails <= 10) $display("ERROR: result word with none expected");
            end else begin
               want = rotations_due.pop_front();
               checked++;
               if (degenerate) degen_seen++;
               if (rot_x !== want.x || rot_y !== want.y || rot_z !== want.z ||
                   rot_w !== want.w || degenerate !== want.degen) begin
                  fails++;
                  if (fails <= 10)
                     $display("ERROR: exp x=%0d y=%0d z=%0d w=%0d dg=%0d got %0d %0d %0d %0d %0d",
                              want.x, want.y, want.z, want.w, want.degen,
                              rot_x, rot_y, rot_z, rot_w, degenerate);
               end
            end
         end
      end
      pending = rotations_due.size();
   end
endmodule

FILE: test/testbench.sv
// Top of the testbench: clock, reset, stimulus and verdict for the quaternion block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid, rsp_degenerate;
   logic signed [15:0] sx = 0, sy = 0, sz = 0, dx = 0, dy = 0, dz = 0;
   logic signed [15:0] rx, ry, rz, rw;
   int fails, pending, checked, degen_seen;
   int idle_pct;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   shortest_arc_rotation_quaternion u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_src_x(sx), .req_src_y(sy), .req_src_z(sz),
      .req_dst_x(dx), .req_dst_y(dy), .req_dst_z(dz),
      .rsp_valid(rsp_valid), .rsp_rot_x(rx), .rsp_rot_y(ry), .rsp_rot_z(rz),
      .rsp_rot_w(rw), .rsp_degenerate(rsp_degenerate)
   );

   sarq_scoreboard u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .src_x(sx), .src_y(sy), .src_z(sz), .dst_x(dx), .dst_y(dy), .dst_z(dz),
      .rsp_valid(rsp_valid), .rot_x(rx), .rot_y(ry), .rot_z(rz), .rot_w(rw),
      .degenerate(rsp_degenerate), .fails(fails), .pending(pending),
      .checked(checked), .degen_seen(degen_seen)
   );

   // drive one word and hold it until taken; an idle gap may come first
   task automatic send_word(int ax, int ay, int az, int bx, int by, int bz);
      logic b;
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      sx <= 16'(ax); sy <= 16'(ay); sz <= 16'(az);
      dx <= 16'(bx); dy <= 16'(by); dz <= 16'(bz);
      do begin
         @(negedge clock);
         b = busy;
         @(posedge clock);
      end while (b);
   endtask

   function automatic int jitter(int v, int span);
      int r;
      r = v + $urandom_range(2 * span) - span;
      return r > 32767 ? 32767 : (r < -32768 ? -32768 : r);
   endfunction

   task automatic random_word();
      int ax, ay, az, k, sh;
      sh = $urandom_range(15);
      ax = $signed(16'($urandom)) >>> sh;
      ay = $signed(16'($urandom)) >>> sh;
      az = $signed(16'($urandom)) >>> sh;
      k = $urandom_range(9);
      case (k)
         0, 1, 2: send_word(ax, ay, az, $signed(16'($urandom)), $signed(16'($urandom)),
                            $signed(16'($urandom)));
         3, 4: send_word(ax, ay, az, $signed(16'($urandom)) >>> sh,
                         $signed(16'($urandom)) >>> sh, $signed(16'($urandom)) >>> sh);
         5, 6: send_word(ax, ay, az, jitter(-ax, 3), jitter(-ay, 3), jitter(-az, 3));
         7: send_word(ax, ay, az, jitter(ax, 3), jitter(ay, 3), jitter(az, 3));
         8: send_word(ax, ay, az, 0, 0, 0);
         default: send_word(jitter(0, 2), jitter(0, 2), jitter(0, 2),
                            jitter(0, 2), jitter(0, 2), jitter(0, 2));
      endcase
   endtask

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int guard;
      repeat (3) @(posedge clock);
      reset <= 0;
      idle_pct = 0;
      // directed: zero, parallel, opposite, orthogonal, extremes, tiny
      send_word(0, 0, 0, 0, 0, 0);
      send_word(4096, 0, 0, 4096, 0, 0);
      send_word(4096, 0, 0, -4096, 0, 0);
      send_word(4096, 0, 0, 0, 4096, 0);
      send_word(0, 4096, 0, 0, 0, 4096);
      send_word(0, 0, 4096, 4096, 0, 0);
      send_word(-32768, -32768, -32768, -32768, -32768, -32768);
      send_word(-32768, -32768, -32768, 32767, 32767, 32767);
      send_word(32767, 32767, 32767, 32767, 32767, 32767);
      send_word(32767, -32768, 32767, -32768, 32767, -32768);
      send_word(32767, 0, 0, 0, 0, -32768);
      send_word(1, 0, 0, 0, 1, 0);
      send_word(1, 1, 1, -1, -1, -1);
      send_word(3, 0, 0, 0, 5, 0);
      send_word(0, 0, 0, 32767, 1, -5);
      send_word(100, 200, -300, -100, -200, 301);
      send_word(4096, 4096, 0, -4096, -4095, 1);
      send_word(-1, 0, 0, 0, 0, 1);
      send_word(20000, -12000, 7, 3, 20000, -12000);
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = ph == 0 ? 31 : (ph == 1 ? 77 : 0);
         for (int n = 0; n < 600; n++) begin
            if (ph == 1 && n == 300) begin
               start <= 0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            random_word();
         end
      end
      start <= 0;
      guard = 0;
      while (pending != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (120) @(posedge clock);
      $display("Checked %0d result words (%0d degenerate) over three idle patterns.",
               checked, degen_seen);
      if (fails == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
